@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(name, clk, rst_n, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(name, clk, rst_n, prop, msg)

`define ASSERT_NEVER(name, clk, rst_n, expr, msg)

`endif

`endif

@@ rtl/jvtc_pkg.sv @@
// ---------------------------------------------------------------------------
// JSON value type classifier package
// Types, character codes and per-byte helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package jvtc_pkg;

  typedef enum logic [2:0] {
    VT_BAD    = 3'd0,
    VT_BOOL   = 3'd1,
    VT_NULL   = 3'd2,
    VT_NUMBER = 3'd3,
    VT_STRING = 3'd4
  } value_type_e;

  typedef struct packed {
    logic [7:0] token_char;
    logic       last_char;
    logic       empty_token;
  } in_item_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  localparam logic [4:0][7:0] TEXT_TRUE  = {"true", 8'h00};
  localparam logic [4:0][7:0] TEXT_FALSE = "false";
  localparam logic [4:0][7:0] TEXT_NULL  = {"null", 8'h00};

  localparam int unsigned NF_EXP   = 0;
  localparam int unsigned NF_DOT   = 1;
  localparam int unsigned NF_FIRST = 2;
  localparam int unsigned NF_NEEDD = 3;
  localparam int unsigned NF_ZERO  = 4;
  localparam int unsigned NF_NONZ  = 5;
  localparam logic [5:0]  NF_RESET = 6'b001100;

  localparam logic [1:0] SP_START  = 2'd0;
  localparam logic [1:0] SP_OPEN   = 2'd1;
  localparam logic [1:0] SP_CLOSED = 2'd2;
  localparam logic [1:0] SP_NOT    = 2'd3;

  localparam logic [2:0] POS_MAX = 3'd7;

  typedef struct packed {
    logic       ok;
    logic [5:0] flags;
  } num_step_t;

  function automatic logic [2:0] lit_len(input logic [1:0] idx);
    case (idx)
      LIT_TRUE:  lit_len = 3'd4;
      LIT_FALSE: lit_len = 3'd5;
      LIT_NULL:  lit_len = 3'd4;
      default:   lit_len = 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] idx, input logic [2:0] pos);
    logic [4:0][7:0] text;
    case (idx)
      LIT_TRUE:  text = TEXT_TRUE;
      LIT_FALSE: text = TEXT_FALSE;
      default:   text = TEXT_NULL;
    endcase
    case (pos)
      3'd0:    lit_char = text[4];
      3'd1:    lit_char = text[3];
      3'd2:    lit_char = text[2];
      3'd3:    lit_char = text[1];
      3'd4:    lit_char = text[0];
      default: lit_char = 8'h00;
    endcase
  endfunction

  function automatic num_step_t number_step(input logic [5:0] f, input logic [7:0] c);
    num_step_t r;
    r.ok    = 1'b1;
    r.flags = f;
    if (c inside {CH_PLUS, CH_MINUS}) begin
      if ((c == CH_PLUS) && !f[NF_EXP]) r.ok = 1'b0;
      if (!f[NF_FIRST]) r.ok = 1'b0;
      r.flags[NF_FIRST] = 1'b0;
    end else if (c inside {CH_UP_E, CH_LO_E}) begin
      if (f[NF_FIRST] || f[NF_NEEDD] || f[NF_EXP]) r.ok = 1'b0;
      r.flags[NF_FIRST] = 1'b1;
      r.flags[NF_NEEDD] = 1'b1;
      r.flags[NF_EXP]   = 1'b1;
      r.flags[NF_DOT]   = 1'b1;
      r.flags[NF_NONZ]  = 1'b0;
    end else if (c == CH_DOT) begin
      if (f[NF_DOT] || f[NF_FIRST] || f[NF_NEEDD] || f[NF_EXP]) r.ok = 1'b0;
      r.flags[NF_DOT]   = 1'b1;
      r.flags[NF_NEEDD] = 1'b1;
    end else if (c inside {[CH_ZERO:CH_NINE]}) begin
      if ((c == CH_ZERO) && !f[NF_NONZ] && !f[NF_DOT]) begin
        if (f[NF_ZERO]) r.ok = 1'b0;
        r.flags[NF_ZERO] = 1'b1;
      end
      if (c != CH_ZERO) r.flags[NF_NONZ] = 1'b1;
      r.flags[NF_FIRST] = 1'b0;
      r.flags[NF_NEEDD] = 1'b0;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/json_value_type_classifier.sv @@
// ---------------------------------------------------------------------------
// JSON value type classifier
// Classifies a streamed JSON scalar token as bool, null, number or string, or as bad.
// ---------------------------------------------------------------------------
// Bytes of one token arrive one per transfer with tlast on the final byte;
// tuser high marks an empty token, which gives a bad result at once. One
// result transfer leaves for each token, at its final byte. The block takes
// one byte per cycle: a byte passes an input register, then updates the token
// state and, if it ends the token, loads the result register, so the result is
// valid once the final byte has passed the input register and the result
// register. Only a final byte or an empty token can wait in the input register,
// and only while the receiver still holds the previous result.
`default_nettype none

`include "assert_macros.svh"

module json_value_type_classifier (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] token_char
  input  wire logic       s_axis_tlast_i,   // last_char
  input  wire logic       s_axis_tuser_i,   // [0] empty_token
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o    // [2:0] value_type, [3] bad_content
);
  import jvtc_pkg::*;

  logic        in_valid_q;
  in_item_t    in_item_q;
  logic        out_valid_q;
  value_type_e out_type_q;
  value_type_e value_type;
  logic        out_free;
  logic        step;
  logic        result_step;

  assign out_free    = !out_valid_q || m_axis_tready_i;
  assign step        = in_valid_q
                       && (!(in_item_q.last_char || in_item_q.empty_token) || out_free);
  assign result_step = step && (in_item_q.last_char || in_item_q.empty_token);

  assign s_axis_tready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q.token_char  <= s_axis_tdata_i;
      in_item_q.last_char   <= s_axis_tlast_i;
      in_item_q.empty_token <= s_axis_tuser_i;
    end
  end

  jvtc_token_state u_token_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .item_i       (in_item_q),
    .value_type_o (value_type)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (result_step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_step) begin
      out_type_q <= value_type;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, (out_type_q == VT_BAD), out_type_q};

  `ASSERT_PROP(a_empty_gives_bad, clk_i, rst_ni,
    (step && in_item_q.empty_token) |=> (out_valid_q && (out_type_q == VT_BAD)),
    "empty token did not produce a bad result")

  `ASSERT_NEVER(a_stall_cause, clk_i, rst_ni,
    !s_axis_tready_o && !(in_valid_q && out_valid_q && !m_axis_tready_i),
    "input stalled without a blocked result")

  `ASSERT_PROP(a_result_only_at_end, clk_i, rst_ni,
    (step && !in_item_q.last_char && !in_item_q.empty_token && !m_axis_tready_i)
      |=> ($stable(out_valid_q)),
    "result register changed on a non-final byte")

endmodule

`default_nettype wire

@@ rtl/jvtc_token_state.sv @@
// ---------------------------------------------------------------------------
// JSON value type classifier token state
// Per-token recognizer state, updated once per byte, and the type decision.
// ---------------------------------------------------------------------------
`default_nettype none

module jvtc_token_state (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire jvtc_pkg::in_item_t  item_i,
  output jvtc_pkg::value_type_e    value_type_o
);
  import jvtc_pkg::*;

  logic [2:0] pos_q, pos_d;
  logic [2:0] lit_alive_q, lit_alive_d;
  logic [5:0] num_flags_q, num_flags_d;
  logic       num_alive_q, num_alive_d;
  logic [1:0] str_phase_q, str_phase_d;
  num_step_t  num_step;
  logic       token_end;

  assign token_end = item_i.last_char || item_i.empty_token;

  always_comb begin
    logic [7:0] c;
    c = item_i.token_char;
    for (int i = 0; i < 3; i++) begin
      lit_alive_d[i] = lit_alive_q[i] && (pos_q < lit_len(2'(i)))
                       && (c == lit_char(2'(i), pos_q));
    end
    num_step    = number_step(num_flags_q, c);
    num_alive_d = num_alive_q && num_step.ok;
    num_flags_d = num_alive_d ? num_step.flags : num_flags_q;
    case (str_phase_q)
      SP_START: str_phase_d = (c == CH_QUOTE) ? SP_OPEN : SP_NOT;
      SP_OPEN:  str_phase_d = (c == CH_QUOTE) ? SP_CLOSED : SP_OPEN;
      default:  str_phase_d = SP_NOT;
    endcase
    pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + 3'd1;
  end

  always_comb begin
    if (item_i.empty_token) begin
      value_type_o = VT_BAD;
    end else if (lit_alive_d[LIT_TRUE] && (pos_d == lit_len(LIT_TRUE))) begin
      value_type_o = VT_BOOL;
    end else if (lit_alive_d[LIT_FALSE] && (pos_d == lit_len(LIT_FALSE))) begin
      value_type_o = VT_BOOL;
    end else if (lit_alive_d[LIT_NULL] && (pos_d == lit_len(LIT_NULL))) begin
      value_type_o = VT_NULL;
    end else if (num_alive_d && !num_flags_d[NF_NEEDD]) begin
      value_type_o = VT_NUMBER;
    end else if (str_phase_d == SP_CLOSED) begin
      value_type_o = VT_STRING;
    end else begin
      value_type_o = VT_BAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      lit_alive_q <= '1;
      num_flags_q <= NF_RESET;
      num_alive_q <= 1'b1;
      str_phase_q <= SP_START;
    end else if (step_i) begin
      if (token_end) begin
        pos_q       <= '0;
        lit_alive_q <= '1;
        num_flags_q <= NF_RESET;
        num_alive_q <= 1'b1;
        str_phase_q <= SP_START;
      end else begin
        pos_q       <= pos_d;
        lit_alive_q <= lit_alive_d;
        num_flags_q <= num_flags_d;
        num_alive_q <= num_alive_d;
        str_phase_q <= str_phase_d;
      end
    end
  end

endmodule

`default_nettype wire
